// ===== hw/rtl/lebdec_pkg.sv =====
package lebdec_pkg;

  localparam logic [1:0] MODE_UNSIGNED = 2'd0;
  localparam logic [1:0] MODE_SIGNED   = 2'd1;
  localparam logic [1:0] MODE_MINUS1   = 2'd2;

  localparam logic [2:0] LAST_POS = 3'd4;
  localparam logic [2:0] LEN_MAX  = 3'd5;

  localparam int unsigned FIFO_DEPTH = 2;
  localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  typedef struct packed {
    logic [31:0] raw;
    logic [2:0]  len;
    logic [1:0]  mode;
  } lebdec_item_t;

endpackage

// ===== hw/rtl/lebdec_front.sv =====
module lebdec_front import lebdec_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_stall_o,
  input  logic [7:0]   data_byte_i,
  input  logic [1:0]   mode_i,
  input  logic         q_full_i,
  output logic         q_push_o,
  output lebdec_item_t q_item_o
);

  logic [2:0]  pos_q, pos_d, pos_eff;
  logic [1:0]  mode_q, mode_eff;
  logic [27:0] acc_q, base, grp, acc_new;
  logic        accept, is_last;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;

  always_comb begin
    pos_eff  = (pos_q > LAST_POS) ? 3'd0 : pos_q;
    base     = (pos_eff == 3'd0) ? 28'd0 : acc_q;
    mode_eff = (pos_eff == 3'd0) ? mode_i : mode_q;
    unique case (pos_eff)
      3'd0:    grp = {21'd0, data_byte_i[6:0]};
      3'd1:    grp = {14'd0, data_byte_i[6:0], 7'd0};
      3'd2:    grp = {7'd0, data_byte_i[6:0], 14'd0};
      3'd3:    grp = {data_byte_i[6:0], 21'd0};
      default: grp = 28'd0;
    endcase
    acc_new = base | grp;
    is_last = (pos_eff == LAST_POS) || !data_byte_i[7];
    pos_d   = is_last ? 3'd0 : pos_eff + 3'd1;
  end

  assign q_push_o      = accept && is_last;
  assign q_item_o.raw  = (pos_eff == LAST_POS) ? {data_byte_i[3:0], base} : {4'd0, acc_new};
  assign q_item_o.len  = pos_eff + 3'd1;
  assign q_item_o.mode = mode_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= 3'd0;
      mode_q <= MODE_UNSIGNED;
    end else if (accept) begin
      pos_q  <= pos_d;
      mode_q <= mode_eff;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      acc_q <= acc_new;
    end
  end

`ifndef SYNTH
  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= LAST_POS) else $error("byte position out of range");
`endif

endmodule

// ===== hw/rtl/lebdec_fifo.sv =====
module lebdec_fifo import lebdec_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  lebdec_item_t item_i,
  output logic         full_o,
  output logic         valid_o,
  input  logic         pop_i,
  output lebdec_item_t item_o
);

  lebdec_item_t         mem_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wr_q, rd_q;
  logic [FIFO_CW-1:0]   cnt_q;
  logic                 do_push, do_pop;

  assign full_o  = (cnt_q == FIFO_CW'(FIFO_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign item_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (rd_q == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      unique case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= item_i;
    end
  end

`ifndef SYNTH
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= FIFO_CW'(FIFO_DEPTH)) else $error("queue count overflow");
  a_cnt_inc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_push && !do_pop) |=> (cnt_q == $past(cnt_q) + 1'b1))
    else $error("queue count did not follow push");
`endif

endmodule

// ===== hw/rtl/lebdec_back.sv =====
module lebdec_back import lebdec_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         q_valid_i,
  input  lebdec_item_t q_item_i,
  output logic         q_pop_o,
  output logic         out_valid_o,
  input  logic         out_stall_i,
  output logic [31:0]  value_o,
  output logic [2:0]   byte_length_o
);

  logic        out_valid_q;
  logic [31:0] value_q, value_d, sext;
  logic [2:0]  len_q;
  logic        load;

  assign load    = q_valid_i && (!out_valid_q || !out_stall_i);
  assign q_pop_o = load;

  always_comb begin
    unique case (q_item_i.len)
      3'd1:    sext = {{25{q_item_i.raw[6]}}, q_item_i.raw[6:0]};
      3'd2:    sext = {{18{q_item_i.raw[13]}}, q_item_i.raw[13:0]};
      3'd3:    sext = {{11{q_item_i.raw[20]}}, q_item_i.raw[20:0]};
      3'd4:    sext = {{4{q_item_i.raw[27]}}, q_item_i.raw[27:0]};
      default: sext = q_item_i.raw;
    endcase
    unique case (q_item_i.mode)
      MODE_SIGNED: value_d = sext;
      MODE_MINUS1: value_d = q_item_i.raw - 32'd1;
      default:     value_d = q_item_i.raw;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      value_q <= value_d;
      len_q   <= q_item_i.len;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign value_o       = value_q;
  assign byte_length_o = len_q;

endmodule

// ===== hw/rtl/leb128_stream_decoder_core.sv =====
// Datapath: a value is written into the queue when its last byte beat is accepted,
// then loaded from the queue into the output register (front stage, queue, output register).
// Throughput: one byte beat per cycle, one value per cycle at most; input stalls
// only when the two-entry queue is full.
// Reset: rst_ni asynchronous, active low; clears byte position, queue and output valid.
module leb128_stream_decoder_core import lebdec_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic [1:0]  mode_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] value_o,
  output logic [2:0]  byte_length_o
);

  lebdec_item_t push_item, pop_item;
  logic         q_push, q_full, q_valid, q_pop;

  lebdec_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .data_byte_i (data_byte_i),
    .mode_i      (mode_i),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_item_o    (push_item)
  );

  lebdec_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (push_item),
    .full_o  (q_full),
    .valid_o (q_valid),
    .pop_i   (q_pop),
    .item_o  (pop_item)
  );

  lebdec_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (q_valid),
    .q_item_i      (pop_item),
    .q_pop_o       (q_pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .value_o       (value_o),
    .byte_length_o (byte_length_o)
  );

`ifndef SYNTH
  a_len_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (byte_length_o != 3'd0 && byte_length_o <= LEN_MAX))
    else $error("byte length out of range");
`endif

endmodule
